// ===== design/pdff_pkg.sv =====
// Package for the per-sender duplicate frame filter.
// Holds the table size, the configuration register indexes and the lookup result type.
// No dependencies.
package pdff_pkg;

  localparam int SENDER_SLOTS = 16;
  localparam int SLOT_W = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;

  localparam int ADDR_W = 32;
  localparam int ID_W = 8;
  localparam int KIND_W = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDRESS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL_TYPE_LIMIT = 8'd1;

  typedef struct packed {
    logic hit;
    logic same_id;
  } lookup_t;

endpackage

// ===== design/pdff_sender_table.sv =====
// One sender table of the duplicate frame filter: parallel compare lookup and store.
// A new sender takes the lowest free slot, or the slot under the round-robin pointer.
// Depends on pdff_pkg.
module pdff_sender_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [pdff_pkg::ADDR_W-1:0] lookup_addr,
  input  logic [pdff_pkg::ID_W-1:0]   lookup_id,
  input  logic                      store_en,
  output pdff_pkg::lookup_t         result
);
  import pdff_pkg::*;

  logic [SENDER_SLOTS-1:0] valid_r;
  logic [ADDR_W-1:0]       sender_r [SENDER_SLOTS];
  logic [ID_W-1:0]         last_id_r [SENDER_SLOTS];
  logic [SLOT_W-1:0]       ptr_r;
  logic [SLOT_W-1:0]       ptr_nxt;

  logic [SENDER_SLOTS-1:0] hit_vec;
  logic [SENDER_SLOTS-1:0] same_vec;
  logic [SENDER_SLOTS-1:0] free_vec;
  logic [SENDER_SLOTS-1:0] first_free;
  logic [SENDER_SLOTS-1:0] ptr_vec;
  logic [SENDER_SLOTS-1:0] wr_vec;
  logic                    any_hit;
  logic                    any_free;

  always_comb begin
    for (int k = 0; k < SENDER_SLOTS; k++) begin
      hit_vec[k]  = valid_r[k] && (sender_r[k] == lookup_addr);
      same_vec[k] = hit_vec[k] && (last_id_r[k] == lookup_id);
      ptr_vec[k]  = (ptr_r == SLOT_W'(k));
    end
    free_vec   = ~valid_r;
    first_free = free_vec & (~free_vec + SENDER_SLOTS'(1));
    any_hit    = |hit_vec;
    any_free   = |free_vec;
    if (any_hit) begin
      wr_vec = hit_vec;
    end else if (any_free) begin
      wr_vec = first_free;
    end else begin
      wr_vec = ptr_vec;
    end
    if (ptr_r == SLOT_W'(SENDER_SLOTS - 1)) begin
      ptr_nxt = '0;
    end else begin
      ptr_nxt = ptr_r + SLOT_W'(1);
    end
  end

  assign result.hit     = any_hit;
  assign result.same_id = |same_vec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ptr_r   <= '0;
    end else if (store_en) begin
      valid_r <= valid_r | wr_vec;
      if (!any_hit && !any_free) begin
        ptr_r <= ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SENDER_SLOTS; k++) begin
      if (store_en && wr_vec[k]) begin
        sender_r[k]  <= lookup_addr;
        last_id_r[k] <= lookup_id;
      end
    end
  end

endmodule

// ===== design/per_sender_duplicate_frame_filter.sv =====
// Top level of the per-sender duplicate frame filter.
// Holds the configuration registers, the input and result registers and two sender tables.
// Depends on pdff_pkg and pdff_sender_table.
//
//   Channel  Signals                                                Direction
//   in       in_valid, in_ready, in_sender_address, in_frame_number,
//            in_frame_kind                                          request in
//   out      out_valid, out_ready, out_accept, out_was_control      result out
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data              register write in
//
// One request per cycle is taken unless the result stalls, via the input and result registers.
// The lookup over all table entries and the table update happen in the cycle the
// request moves from the input register into the result register.
// A stalled result holds the input register and so in_ready low; cfg_ready is always high.
// Synchronous reset clears the table valid bits, the pointers, the config and valid registers.
module per_sender_duplicate_frame_filter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pdff_pkg::ADDR_W-1:0]       in_sender_address,
  input  logic [pdff_pkg::ID_W-1:0]         in_frame_number,
  input  logic [pdff_pkg::KIND_W-1:0]       in_frame_kind,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_accept,
  output logic                              out_was_control,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pdff_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pdff_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pdff_pkg::*;

  logic [ADDR_W-1:0] own_address_r;
  logic [KIND_W-1:0] control_type_limit_r;

  logic              s1_valid_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [ID_W-1:0]   s1_id_r;
  logic [KIND_W-1:0] s1_kind_r;

  logic              out_valid_r;
  logic              out_accept_r;
  logic              out_was_control_r;

  logic              advance;
  logic              is_ctrl;
  logic              frame_ok;
  lookup_t           ctrl_res;
  lookup_t           data_res;
  lookup_t           sel_res;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;

  assign is_ctrl  = s1_kind_r < control_type_limit_r;
  assign sel_res  = is_ctrl ? ctrl_res : data_res;
  assign frame_ok = !sel_res.same_id || (is_ctrl && (s1_addr_r == own_address_r));

  pdff_sender_table u_ctrl_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_addr (s1_addr_r),
    .lookup_id   (s1_id_r),
    .store_en    (advance && is_ctrl && frame_ok),
    .result      (ctrl_res)
  );

  pdff_sender_table u_data_table (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_addr (s1_addr_r),
    .lookup_id   (s1_id_r),
    .store_en    (advance && !is_ctrl && frame_ok),
    .result      (data_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_address_r        <= '0;
      control_type_limit_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_OWN_ADDRESS:        own_address_r        <= cfg_data[ADDR_W-1:0];
        CFG_CONTROL_TYPE_LIMIT: control_type_limit_r <= cfg_data[KIND_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_addr_r <= in_sender_address;
      s1_id_r   <= in_frame_number;
      s1_kind_r <= in_frame_kind;
    end
    if (advance) begin
      out_accept_r      <= frame_ok;
      out_was_control_r <= is_ctrl;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accept      = out_accept_r;
  assign out_was_control = out_was_control_r;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the per-sender duplicate frame filter.
// Predicts each verdict from its own copy of both sender tables and checks every result.
// Depends on pdff_pkg and the per_sender_duplicate_frame_filter RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pdff_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD = 150;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_UNUSED = CFG_CONTROL_TYPE_LIMIT + 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LAST_UNUSED = 8'hFF;
  localparam int POOL_DEPTH = 24;

  typedef enum int {DATA_TAB = 0, CTRL_TAB = 1} tab_sel_t;

  typedef struct packed {
    bit [ADDR_W-1:0] addr;
    bit [ID_W-1:0]   id;
    bit [KIND_W-1:0] kind;
  } frame_t;

  typedef struct packed {
    bit accept;
    bit was_control;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [ADDR_W-1:0]      in_sender_address = '0;
  logic [ID_W-1:0]        in_frame_number = '0;
  logic [KIND_W-1:0]      in_frame_kind = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   out_accept;
  logic                   out_was_control;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bit              slot_used [2][SENDER_SLOTS];
  bit [ADDR_W-1:0] slot_sender [2][SENDER_SLOTS];
  bit [ID_W-1:0]   slot_id [2][SENDER_SLOTS];
  int unsigned     slot_ptr [2];
  bit [ADDR_W-1:0] own_addr_q = '0;
  bit [KIND_W-1:0] kind_limit_q = '0;

  frame_t          frames_to_send[$];
  verdict_t        pending_verdicts[$];
  bit [ADDR_W-1:0] sender_pool [POOL_DEPTH];

  int  idle_pct = 0;
  bit  calm = 1'b0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  long_hold_ticket = 0;
  int  long_hold_served = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  accepted_total = 0;
  int  rejected_total = 0;
  int  control_total = 0;
  int  settings_total = 0;

  per_sender_duplicate_frame_filter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_sender_address(in_sender_address), .in_frame_number(in_frame_number),
    .in_frame_kind(in_frame_kind),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_accept(out_accept), .out_was_control(out_was_control),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic verdict_t judge_frame(bit [ADDR_W-1:0] addr, bit [ID_W-1:0] id,
                                           bit [KIND_W-1:0] kind);
    tab_sel_t t;
    int       hit;
    int       slot;
    int       k;
    verdict_t v;
    t = (kind < kind_limit_q) ? CTRL_TAB : DATA_TAB;
    hit = -1;
    for (k = 0; k < SENDER_SLOTS; k++) begin
      if (hit < 0 && slot_used[t][k] && slot_sender[t][k] == addr) hit = k;
    end
    v.was_control = (t == CTRL_TAB);
    v.accept = 1'b1;
    if (hit >= 0 && slot_id[t][hit] == id && !(t == CTRL_TAB && addr == own_addr_q)) begin
      v.accept = 1'b0;
    end
    if (v.accept) begin
      slot = hit;
      for (k = 0; k < SENDER_SLOTS; k++) begin
        if (slot < 0 && !slot_used[t][k]) slot = k;
      end
      if (slot < 0) begin
        slot = int'(slot_ptr[t]);
        slot_ptr[t] = (slot_ptr[t] + 1) % SENDER_SLOTS;
      end
      slot_used[t][slot] = 1'b1;
      slot_sender[t][slot] = addr;
      slot_id[t][slot] = id;
      accepted_total++;
    end else begin
      rejected_total++;
    end
    if (v.was_control) control_total++;
    return v;
  endfunction

  function automatic void note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  always @(posedge clk) begin : drive_frames
    logic   next_valid;
    frame_t f;
    if (rst_n) begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        pending_verdicts.push_back(judge_frame(in_sender_address, in_frame_number,
                                               in_frame_kind));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (frames_to_send.size() > 0) begin
          f = frames_to_send.pop_front();
          in_sender_address <= f.addr;
          in_frame_number <= f.id;
          in_frame_kind <= f.kind;
          next_valid = 1'b1;
          if (!calm && $urandom_range(99) < idle_pct) send_gap = $urandom_range(19, 1);
        end
      end
      in_valid <= next_valid;
    end
  end

  always @(posedge clk) begin : pace_results
    if (rst_n) begin
      if (long_hold_served != long_hold_ticket) begin
        long_hold_served = long_hold_ticket;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(99) < idle_pct) stall_left = $urandom_range(19, 1);
      end
    end
  end

  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        note_failure($sformatf("result accept=%b was_control=%b with no request pending",
                               out_accept, out_was_control));
      end else begin
        want = pending_verdicts.pop_front();
        if (out_accept !== want.accept)
          note_failure($sformatf("accept expected %b got %b", want.accept, out_accept));
        if (out_was_control !== want.was_control)
          note_failure($sformatf("was_control expected %b got %b",
                                 want.was_control, out_was_control));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("per_sender_duplicate_frame_filter regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      CFG_OWN_ADDRESS: own_addr_q = val;
      CFG_CONTROL_TYPE_LIMIT: kind_limit_q = val[KIND_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (frames_to_send.size() != 0 || in_valid || pending_verdicts.size() != 0);
  endtask

  task automatic queue_frame(input bit [ADDR_W-1:0] addr, input bit [ID_W-1:0] id,
                             input bit [KIND_W-1:0] kind);
    frame_t f;
    f.addr = addr;
    f.id = id;
    f.kind = kind;
    frames_to_send.push_back(f);
  endtask

  // Starts a new setting: registers are written while the block is empty.
  task automatic start_setting(input bit [ADDR_W-1:0] own, input logic [CFG_DATA_W-1:0] limit,
                               input int pct, input bit hold);
    int k;
    wait_drained();
    write_reg(CFG_OWN_ADDRESS, own);
    write_reg(CFG_CONTROL_TYPE_LIMIT, limit);
    @(negedge clk);
    settings_total++;
    idle_pct = pct;
    if (hold) long_hold_ticket++;
    for (k = 0; k < POOL_DEPTH; k++) sender_pool[k] = $urandom;
    sender_pool[0] = own;
    sender_pool[1] = '0;
    sender_pool[2] = '1;
  endtask

  // Mostly senders from a small pool with few ids, so that repeats and table
  // overflow are common; some frames are sent twice in a row on purpose.
  task automatic queue_random_frames(input int count);
    int              n;
    int              pool_used;
    bit [ADDR_W-1:0] addr;
    bit [ID_W-1:0]   id;
    bit [KIND_W-1:0] kind;
    n = 0;
    while (n < count) begin
      if (n % 50 == 0) pool_used = ($urandom_range(1)) ? 12 : POOL_DEPTH;
      addr = ($urandom_range(99) < 85) ? sender_pool[$urandom_range(pool_used - 1)] : $urandom;
      id = ($urandom_range(99) < 70) ? ID_W'($urandom_range(3)) : ID_W'($urandom_range(255));
      case ($urandom_range(2))
        0: kind = KIND_W'($urandom_range(255));
        1: kind = KIND_W'(kind_limit_q + $urandom_range(2) - 1);
        default: kind = ($urandom_range(1)) ? 8'h00 : 8'hFF;
      endcase
      queue_frame(addr, id, kind);
      n++;
      if (n < count && $urandom_range(99) < 20) begin
        queue_frame(addr, id, kind);
        n++;
      end
    end
  endtask

  initial begin : run_regression
    bit [ADDR_W-1:0] own_pick;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    settings_total = 1;
    idle_pct = 30;
    queue_frame('0, '0, '0);
    queue_frame('0, '0, '0);

    own_pick = $urandom;
    start_setting(own_pick, 32'h80, 30, 1'b0);
    queue_frame(own_pick, 8'd5, 8'hFF);
    queue_frame(own_pick, 8'd5, 8'hFF);
    queue_frame(own_pick, 8'd6, 8'h80);
    queue_frame(own_pick, 8'd6, 8'h00);
    queue_frame(own_pick, 8'd6, 8'h00);
    queue_frame(~own_pick, 8'd6, 8'h7F);
    queue_frame(~own_pick, 8'd6, 8'h7F);
    queue_frame(~own_pick, 8'd0, 8'h80);
    queue_frame('0, 8'd0, 8'hFF);
    queue_frame('1, 8'hFF, 8'hFF);
    queue_frame('1, 8'hFF, 8'hFF);
    queue_random_frames(200);

    start_setting('1, 32'hFF, 40, 1'b1);
    queue_random_frames(150);

    wait_drained();
    write_reg(CFG_FIRST_UNUSED, $urandom);
    write_reg(CFG_LAST_UNUSED, '1);
    start_setting('0, 32'h0, 20, 1'b0);
    queue_random_frames(150);

    start_setting('0, 32'h1, 0, 1'b0);
    queue_random_frames(150);

    start_setting($urandom, 32'hABCDEF40, 50, 1'b1);
    queue_random_frames(150);

    start_setting($urandom, 32'h80, 0, 1'b0);
    calm = 1'b1;
    queue_random_frames(150);

    wait_drained();
    repeat (8) @(negedge clk);
    if (pending_verdicts.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_verdicts.size()));
    $display("Checked %0d frames over %0d register settings: %0d accepted, %0d duplicates",
             accepted_total + rejected_total, settings_total, accepted_total, rejected_total);
    $display("rejected, %0d classed as control; %0d mismatches.", control_total, mismatch_count);
    if (mismatch_count == 0) begin
      $display("per_sender_duplicate_frame_filter regression: pass");
    end else begin
      $display("per_sender_duplicate_frame_filter regression: fail");
    end
    $finish;
  end

endmodule
